/* hw/rtl/s2a_pkg.sv */
// ----------------------------------------------------------------------------
// s2a_pkg: shared types and constants for the SCSI-to-ATA command translator
// Command and result word layouts, opcodes, action and status codes.
// ----------------------------------------------------------------------------
package s2a_pkg;

  localparam int PORT_COUNT = 32;

  // SCSI opcodes
  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_WRITE6          = 8'h0A;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_MODE_SENSE      = 8'h1A;
  localparam logic [7:0] OP_MEDIUM_REMOVAL  = 8'h1E;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2A;
  localparam logic [7:0] OP_VERIFY          = 8'h2F;
  localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;

  // actions
  localparam logic [2:0] ACT_REJECT     = 3'd0;
  localparam logic [2:0] ACT_GOOD       = 3'd1;
  localparam logic [2:0] ACT_ATA        = 3'd2;
  localparam logic [2:0] ACT_PACKET     = 3'd3;
  localparam logic [2:0] ACT_INQUIRY    = 3'd4;
  localparam logic [2:0] ACT_CAPACITY   = 3'd5;
  localparam logic [2:0] ACT_MODE_SENSE = 3'd6;

  // request status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_NO_DEVICE = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // ATA command bytes and FIS fields
  localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
  localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;
  localparam logic [7:0] ATA_PACKET        = 8'hA0;
  localparam logic [7:0] DEV_LBA_MODE      = 8'h40;
  localparam logic [7:0] FEAT_PACKET_DMA   = 8'h01;

  // command header flags
  localparam logic [6:0] HDR_FIS_DWORDS = 7'd5;
  localparam logic [6:0] HDR_ATAPI      = 7'h20;
  localparam logic [6:0] HDR_WRITE      = 7'h40;

  localparam logic [15:0] CDB6_ZERO_COUNT = 16'd256;

  typedef struct packed {
    logic [7:0]  target_port;
    logic [7:0]  logical_unit;
    logic [63:0] cdb_head;
    logic [15:0] cdb_tail;
    logic [31:0] transfer_length;
    logic        port_present;
    logic        port_is_atapi;
  } command_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  request_status;
    logic [7:0]  ata_command;
    logic        write_direction;
    logic [31:0] block_address;
    logic [15:0] block_count;
    logic [7:0]  device_byte;
    logic [7:0]  feature_byte;
    logic [15:0] byte_count_limit;
    logic [6:0]  header_flags;
  } result_t;

endpackage

/* hw/rtl/s2a_decode.sv */
// ----------------------------------------------------------------------------
// s2a_decode: command decode
// Target/LUN check, opcode decode and FIS field build for one command word.
// ----------------------------------------------------------------------------
module s2a_decode (
  input  s2a_pkg::command_t command,
  output s2a_pkg::result_t  result
);

  logic [7:0]  op;
  logic        port_ok;
  logic        wr6;
  logic        wr10;
  logic [31:0] lba6;
  logic [15:0] cnt6;
  logic [31:0] lba10;
  logic [15:0] cnt10;

  function automatic s2a_pkg::result_t build_packet(logic wr, logic [31:0] xfer);
    s2a_pkg::result_t r;
    r                  = '0;
    r.action           = s2a_pkg::ACT_PACKET;
    r.request_status   = s2a_pkg::ST_OK;
    r.ata_command      = s2a_pkg::ATA_PACKET;
    r.write_direction  = wr;
    r.feature_byte     = s2a_pkg::FEAT_PACKET_DMA;
    r.byte_count_limit = xfer[15:0];
    r.header_flags     = s2a_pkg::HDR_FIS_DWORDS | s2a_pkg::HDR_ATAPI |
                         (wr ? s2a_pkg::HDR_WRITE : 7'd0);
    return r;
  endfunction

  function automatic s2a_pkg::result_t build_ata(logic wr, logic [31:0] lba,
                                                 logic [15:0] cnt);
    s2a_pkg::result_t r;
    r                 = '0;
    r.action          = s2a_pkg::ACT_ATA;
    r.request_status  = s2a_pkg::ST_OK;
    r.ata_command     = wr ? s2a_pkg::ATA_WRITE_DMA_EXT : s2a_pkg::ATA_READ_DMA_EXT;
    r.write_direction = wr;
    r.block_address   = lba;
    r.block_count     = cnt;
    r.device_byte     = s2a_pkg::DEV_LBA_MODE;
    r.header_flags    = s2a_pkg::HDR_FIS_DWORDS | (wr ? s2a_pkg::HDR_WRITE : 7'd0);
    return r;
  endfunction

  assign op      = command.cdb_head[63:56];
  assign port_ok = (command.target_port < 8'(s2a_pkg::PORT_COUNT)) && command.port_present;
  assign wr6     = (op == s2a_pkg::OP_WRITE6);
  assign wr10    = (op == s2a_pkg::OP_WRITE10);
  assign lba6    = {11'd0, command.cdb_head[52:48], command.cdb_head[47:32]};
  assign cnt6    = (command.cdb_head[31:24] == 8'd0) ? s2a_pkg::CDB6_ZERO_COUNT
                                                     : {8'd0, command.cdb_head[31:24]};
  assign lba10   = command.cdb_head[47:16];
  assign cnt10   = {command.cdb_head[7:0], command.cdb_tail[15:8]};

  always_comb begin
    result = '0;
    if (!port_ok) begin
      result.action         = s2a_pkg::ACT_REJECT;
      result.request_status = s2a_pkg::ST_TIMEOUT;
    end else if (command.logical_unit != 8'd0) begin
      result.action         = s2a_pkg::ACT_REJECT;
      result.request_status = s2a_pkg::ST_NO_DEVICE;
    end else begin
      case (op)
        s2a_pkg::OP_INQUIRY: begin
          result.action = s2a_pkg::ACT_INQUIRY;
        end
        s2a_pkg::OP_TEST_UNIT_READY,
        s2a_pkg::OP_SYNC_CACHE,
        s2a_pkg::OP_VERIFY,
        s2a_pkg::OP_MEDIUM_REMOVAL: begin
          result.action = s2a_pkg::ACT_GOOD;
        end
        s2a_pkg::OP_READ_CAPACITY: begin
          if (command.port_is_atapi) begin
            result = build_packet(1'b0, command.transfer_length);
          end else begin
            result.action = s2a_pkg::ACT_CAPACITY;
          end
        end
        s2a_pkg::OP_MODE_SENSE: begin
          result.action = s2a_pkg::ACT_MODE_SENSE;
        end
        s2a_pkg::OP_READ6,
        s2a_pkg::OP_WRITE6: begin
          if (command.port_is_atapi) begin
            result = build_packet(wr6, command.transfer_length);
          end else begin
            result = build_ata(wr6, lba6, cnt6);
          end
        end
        s2a_pkg::OP_READ10,
        s2a_pkg::OP_WRITE10: begin
          if (command.port_is_atapi) begin
            result = build_packet(wr10, command.transfer_length);
          end else begin
            result = build_ata(wr10, lba10, cnt10);
          end
        end
        default: begin
          if (command.port_is_atapi) begin
            result = build_packet(1'b0, command.transfer_length);
          end else begin
            result.action         = s2a_pkg::ACT_REJECT;
            result.request_status = s2a_pkg::ST_INVALID;
          end
        end
      endcase
    end
  end

endmodule

/* hw/rtl/scsi_to_ata_command_translator_core.sv */
// ----------------------------------------------------------------------------
// scsi_to_ata_command_translator_core: SCSI-to-ATA command translator
// Registers each command word, decodes it and registers the result word.
// ----------------------------------------------------------------------------
// A command word is taken on every clock in which start is high; busy never
// rises, so commands may be issued back to back, one per cycle. Each command
// yields exactly one result word, presented on result with done high for one
// cycle, once it has passed the input register and then the result register.
// Results come out in command order and cannot be held off, so the receiver
// must take every word in the cycle it appears.
module scsi_to_ata_command_translator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  s2a_pkg::command_t command,
  output logic              done,
  output s2a_pkg::result_t  result
);

  logic              in_valid;
  s2a_pkg::command_t in_cmd;
  s2a_pkg::result_t  dec_result;

  assign busy = 1'b0;

  s2a_decode u_decode (
    .command (in_cmd),
    .result  (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
    if (start && !busy) begin
      in_cmd <= command;
    end
    if (in_valid) begin
      result <= dec_result;
    end
  end

  // one result per command, through the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start, 2)))
    else $error("result strobe does not follow command by two cycles");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.request_status != s2a_pkg::ST_OK) |->
    (result.action == s2a_pkg::ACT_REJECT && result.ata_command == 8'd0))
    else $error("failed request carries a translated command");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.action == s2a_pkg::ACT_ATA) |->
    (result.device_byte == s2a_pkg::DEV_LBA_MODE && !result.header_flags[5]))
    else $error("ATA DMA result with bad FIS fields");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.action != s2a_pkg::ACT_ATA && result.action != s2a_pkg::ACT_PACKET) |->
    (result.ata_command == 8'd0 && result.header_flags == 7'd0 &&
     !result.write_direction))
    else $error("local action carries command fields");

endmodule
